@@ hdl/vec3_arithmetic_unit_top_macros.svh @@
// Assertion macros shared by the vector unit RTL.
`ifndef VEC3_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define VEC3_ARITHMETIC_UNIT_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define V3AU_ASSERT_IMPLIES(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define V3AU_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define V3AU_ASSERT_IMPLIES(lbl, ck, rst_n, ante, cons, msg)
`define V3AU_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg)
`endif
`endif

@@ hdl/v3au_pkg.sv @@
// Shared types, command codes and pipeline depths of the vector unit.
package v3au_pkg;

	localparam logic [3:0] CMD_ADD    = 4'd0;
	localparam logic [3:0] CMD_SUB    = 4'd1;
	localparam logic [3:0] CMD_CROSS  = 4'd2;
	localparam logic [3:0] CMD_SCALE  = 4'd3;
	localparam logic [3:0] CMD_DOT    = 4'd4;
	localparam logic [3:0] CMD_MAGSQ  = 4'd5;
	localparam logic [3:0] CMD_MAG    = 4'd6;
	localparam logic [3:0] CMD_NORM   = 4'd7;
	localparam logic [3:0] CMD_SETMAG = 4'd8;

	localparam int SQ_STEPS  = 32;
	localparam int DIV_STEPS = 32;
	localparam int SQ_LAT    = SQ_STEPS + 1;
	localparam int DIV_LAT   = DIV_STEPS + 2;

	typedef logic signed [31:0] fx_t;
	typedef logic signed [63:0] prod_t;

	typedef struct packed {
		logic [3:0]      cmd;
		fx_t [2:0]       vec;
		fx_t             scal;
		logic            sat;
		logic            zero;
		prod_t [2:0]     num;
	} side_t;

endpackage

@@ hdl/v3au_lane.sv @@
// One vector lane: two registered 32x32 signed multipliers.
module v3au_lane (
	input  logic               clk,
	input  logic signed [31:0] xa,
	input  logic signed [31:0] ya,
	input  logic signed [31:0] xb,
	input  logic signed [31:0] yb,
	output logic signed [63:0] pa_s2,
	output logic signed [63:0] pb_s2
);

	always_ff @(posedge clk) begin
		pa_s2 <= xa * ya;
		pb_s2 <= xb * yb;
	end

endmodule

@@ hdl/v3au_sqrt.sv @@
// Pipelined rounded integer square root, one root bit per stage, with sideband.
module v3au_sqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  logic [63:0]         in_rad,
	input  v3au_pkg::side_t     in_side,
	output logic                out_vld,
	output logic [32:0]         out_root,
	output v3au_pkg::side_t     out_side
);

	localparam int N = v3au_pkg::SQ_STEPS;

	logic            vld_s  [N+1];
	logic [33:0]     rem_s  [N+1];
	logic [31:0]     root_s [N+1];
	logic [63:0]     rad_s  [N+1];
	v3au_pkg::side_t side_s [N+1];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = in_rad;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [35:0] trial;
		logic [35:0] tsub;
		logic        ge;

		assign trial = {rem_s[k], rad_s[k][63:62]};
		assign tsub  = {2'b00, root_s[k], 2'b01};
		assign ge    = trial >= tsub;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? 34'(trial - tsub) : trial[33:0];
			root_s[k+1] <= {root_s[k][30:0], ge};
			rad_s[k+1]  <= {rad_s[k][61:0], 2'b00};
			side_s[k+1] <= side_s[k];
		end
	end

	// round up when the remainder exceeds the floor root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		out_root <= {1'b0, root_s[N]} + 33'(rem_s[N] > {2'b00, root_s[N]});
		out_side <= side_s[N];
	end

endmodule

@@ hdl/v3au_div.sv @@
// Pipelined signed divide with round half away from zero and 32-bit saturation.
module v3au_div (
	input  logic               clk,
	input  logic signed [63:0] num,
	input  logic [32:0]        den,
	output logic signed [31:0] quo,
	output logic               sat
);

	localparam int N = v3au_pkg::DIV_STEPS;

	logic [63:0] mag;
	logic [63:0] dvd;
	logic        ovf;

	logic [31:0] d_s   [N+1];
	logic [32:0] rem_s [N+1];
	logic [31:0] q_s   [N+1];
	logic [32:0] den_s [N+1];
	logic        ovf_s [N+1];
	logic        neg_s [N+1];

	assign mag = num[63] ? 64'(-num) : 64'(num);
	assign dvd = mag + {32'b0, den[32:1]};
	assign ovf = {1'b0, dvd} >= {den, 32'b0};

	always_ff @(posedge clk) begin
		d_s[0]   <= dvd[31:0];
		rem_s[0] <= {1'b0, dvd[63:32]};
		q_s[0]   <= '0;
		den_s[0] <= den;
		ovf_s[0] <= ovf;
		neg_s[0] <= num[63];
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [33:0] trial;
		logic        ge;

		assign trial = {rem_s[k], d_s[k][31]};
		assign ge    = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? 33'(trial - {1'b0, den_s[k]}) : trial[32:0];
			q_s[k+1]   <= {q_s[k][30:0], ge};
			d_s[k+1]   <= {d_s[k][30:0], 1'b0};
			den_s[k+1] <= den_s[k];
			ovf_s[k+1] <= ovf_s[k];
			neg_s[k+1] <= neg_s[k];
		end
	end

	logic        sat_d;
	logic [31:0] quo_d;

	always_comb begin
		if (neg_s[N]) begin
			sat_d = ovf_s[N] || (q_s[N] > 32'h8000_0000);
			quo_d = sat_d ? 32'h8000_0000 : 32'(-q_s[N]);
		end else begin
			sat_d = ovf_s[N] || q_s[N][31];
			quo_d = sat_d ? 32'h7FFF_FFFF : q_s[N];
		end
	end

	always_ff @(posedge clk) begin
		quo <= $signed(quo_d);
		sat <= sat_d;
	end

endmodule

@@ hdl/vec3_arithmetic_unit_top.sv @@
// Top level of the three-component fixed-point vector unit.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+-------------------------
//  input   | cmd a_x a_y a_z b_x b_y b_z factor        | beat when start && !busy
//  result  | r_x r_y r_z r_scalar zero_length saturated| beat when done, 1 cycle
//
// One beat is taken every clock; busy stays low. Each result leaves after passing the input
// stage, the lanes, the merge stage, the square root and the divider in series.
// Reset clears only the valid chain. The receiver cannot stall the results.
module vec3_arithmetic_unit_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         cmd,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	input  logic signed [31:0] factor,
	output logic               done,
	output logic signed [31:0] r_x,
	output logic signed [31:0] r_y,
	output logic signed [31:0] r_z,
	output logic signed [31:0] r_scalar,
	output logic               zero_length,
	output logic               saturated
);

	localparam int DL  = v3au_pkg::DIV_LAT;
	localparam int LAT = 2 + v3au_pkg::SQ_LAT + DL + 1;

	localparam logic signed [66:0] HALF     = 67'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [66:0] WIDE_MAX = 67'sd2147483647;
	localparam logic signed [66:0] WIDE_MIN = -67'sd2147483648;
	localparam logic signed [31:0] ONE32    = 32'sd1 <<< FRAC_BITS;
	localparam logic [32:0]        ONE_DEN  = 33'd1 << FRAC_BITS;

	function automatic logic [32:0] fx_sat(input logic signed [66:0] v);
		logic [32:0] r;
		if (v > WIDE_MAX) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < WIDE_MIN) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	function automatic logic [32:0] fx_reduce(input logic signed [66:0] x);
		logic signed [66:0] y;
		y = (x + HALF) >>> FRAC_BITS;
		return fx_sat(y);
	endfunction

	// input stage
	logic               vld_s1;
	logic [3:0]         cmd_s1;
	logic signed [31:0] a_s1 [3];
	logic signed [31:0] b_s1 [3];
	logic signed [31:0] f_s1;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_s1  <= cmd;
			a_s1[0] <= a_x;
			a_s1[1] <= a_y;
			a_s1[2] <= a_z;
			b_s1[0] <= b_x;
			b_s1[1] <= b_y;
			b_s1[2] <= b_z;
			f_s1    <= factor;
		end
	end

	// lanes
	logic               vld_s2;
	logic [3:0]         cmd_s2;
	logic signed [32:0] addsub_s2 [3];
	logic signed [63:0] pa_s2 [3];
	logic signed [63:0] pb_s2 [3];
	logic [32:0]        vres [3];

	for (genvar i = 0; i < 3; i++) begin : g_lane
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;

		logic signed [31:0] xa;
		logic signed [31:0] ya;
		logic signed [31:0] xb;
		logic signed [31:0] yb;

		always_comb begin
			xa = a_s1[i];
			ya = a_s1[i];
			xb = a_s1[i];
			yb = ONE32;
			case (cmd_s1)
				v3au_pkg::CMD_CROSS: begin
					xa = a_s1[J];
					ya = b_s1[K];
					xb = a_s1[K];
					yb = b_s1[J];
				end
				v3au_pkg::CMD_SCALE: ya = f_s1;
				v3au_pkg::CMD_DOT: ya = b_s1[i];
				v3au_pkg::CMD_SETMAG: yb = f_s1;
				default: xa = a_s1[i];
			endcase
		end

		v3au_lane u_lane (
			.clk   (clk),
			.xa    (xa),
			.ya    (ya),
			.xb    (xb),
			.yb    (yb),
			.pa_s2 (pa_s2[i]),
			.pb_s2 (pb_s2[i])
		);

		always_ff @(posedge clk) begin
			if (cmd_s1 == v3au_pkg::CMD_SUB) begin
				addsub_s2[i] <= 33'(a_s1[i]) - 33'(b_s1[i]);
			end else begin
				addsub_s2[i] <= 33'(a_s1[i]) + 33'(b_s1[i]);
			end
		end

		always_comb begin
			case (cmd_s2)
				v3au_pkg::CMD_ADD, v3au_pkg::CMD_SUB: vres[i] = fx_sat(67'(addsub_s2[i]));
				v3au_pkg::CMD_CROSS: vres[i] = fx_reduce(67'(pa_s2[i]) - 67'(pb_s2[i]));
				v3au_pkg::CMD_SCALE: vres[i] = fx_reduce(67'(pa_s2[i]));
				default: vres[i] = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s2 <= cmd_s1;
	end

	// merge stage
	logic signed [65:0] sum_all;
	logic [32:0]        sres;
	v3au_pkg::side_t    side_d;
	v3au_pkg::side_t    side_s3;
	logic [63:0]        sumsq_s3;
	logic               vld_s3;

	assign sum_all = 66'(pa_s2[0]) + 66'(pa_s2[1]) + 66'(pa_s2[2]);

	always_comb begin
		case (cmd_s2)
			v3au_pkg::CMD_DOT, v3au_pkg::CMD_MAGSQ: sres = fx_reduce(67'(sum_all));
			default: sres = '0;
		endcase
		side_d.cmd  = cmd_s2;
		side_d.vec  = {vres[2][31:0], vres[1][31:0], vres[0][31:0]};
		side_d.scal = sres[31:0];
		side_d.sat  = vres[0][32] | vres[1][32] | vres[2][32] | sres[32];
		side_d.zero = (sum_all == '0) && (cmd_s2 inside {v3au_pkg::CMD_NORM,
			v3au_pkg::CMD_SETMAG});
		side_d.num  = {pb_s2[2], pb_s2[1], pb_s2[0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s3  <= side_d;
		sumsq_s3 <= sum_all[63:0];
	end

	// magnitude
	logic            sq_vld;
	logic [32:0]     sq_root;
	v3au_pkg::side_t sq_side;
	v3au_pkg::side_t side_m;
	logic [32:0]     den;

	v3au_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s3),
		.in_rad   (sumsq_s3),
		.in_side  (side_s3),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	always_comb begin
		side_m = sq_side;
		if (sq_side.cmd == v3au_pkg::CMD_MAG) begin
			side_m.sat  = |sq_root[32:31];
			side_m.scal = side_m.sat ? 32'sh7FFF_FFFF : $signed(sq_root[31:0]);
		end
		den = sq_side.zero ? ONE_DEN : sq_root;
	end

	// per-lane division
	logic signed [31:0] quo [3];
	logic               dsat [3];

	for (genvar i = 0; i < 3; i++) begin : g_div
		v3au_div u_div (
			.clk (clk),
			.num (sq_side.num[i]),
			.den (den),
			.quo (quo[i]),
			.sat (dsat[i])
		);
	end

	logic            vld_ln  [DL];
	v3au_pkg::side_t side_ln [DL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DL; k++) begin
				vld_ln[k] <= 1'b0;
			end
		end else begin
			vld_ln[0] <= sq_vld;
			for (int k = 1; k < DL; k++) begin
				vld_ln[k] <= vld_ln[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_ln[0] <= side_m;
		for (int k = 1; k < DL; k++) begin
			side_ln[k] <= side_ln[k-1];
		end
	end

	// output register
	v3au_pkg::side_t    side_o;
	logic               done_q;
	logic signed [31:0] r_x_q;
	logic signed [31:0] r_y_q;
	logic signed [31:0] r_z_q;
	logic signed [31:0] r_scalar_q;
	logic               zero_q;
	logic               sat_q;
	logic               use_div;

	assign side_o  = side_ln[DL-1];
	assign use_div = side_o.cmd inside {v3au_pkg::CMD_NORM, v3au_pkg::CMD_SETMAG};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_ln[DL-1];
		end
	end

	always_ff @(posedge clk) begin
		r_x_q      <= use_div ? quo[0] : $signed(side_o.vec[0]);
		r_y_q      <= use_div ? quo[1] : $signed(side_o.vec[1]);
		r_z_q      <= use_div ? quo[2] : $signed(side_o.vec[2]);
		r_scalar_q <= side_o.scal;
		zero_q     <= side_o.zero;
		sat_q      <= side_o.sat | (use_div & (dsat[0] | dsat[1] | dsat[2]));
	end

	assign done        = done_q;
	assign r_x         = r_x_q;
	assign r_y         = r_y_q;
	assign r_z         = r_z_q;
	assign r_scalar    = r_scalar_q;
	assign zero_length = zero_q;
	assign saturated   = sat_q;

`include "vec3_arithmetic_unit_top_macros.svh"

	`V3AU_ASSERT_IMPLIES(a_latency, clk, arst_n, 1'b1, done == $past(vld_s1, LAT), "result beat out of step with input beat")
	`V3AU_ASSERT_IMPLIES(a_zero_out, clk, arst_n, done && zero_length, r_x == 32'sd0 && r_y == 32'sd0 && r_z == 32'sd0 && r_scalar == 32'sd0, "zero-length result not all zero")
	`V3AU_ASSERT_IMPLIES(a_sat_clamp, clk, arst_n, done && saturated, r_x == 32'sh7FFF_FFFF || r_x == 32'sh8000_0000 || r_y == 32'sh7FFF_FFFF || r_y == 32'sh8000_0000 || r_z == 32'sh7FFF_FFFF || r_z == 32'sh8000_0000 || r_scalar == 32'sh7FFF_FFFF || r_scalar == 32'sh8000_0000, "saturated without a clamped field")
	`V3AU_ASSERT_NEXT(a_take, clk, arst_n, start, vld_s1, "input beat dropped")

endmodule

@@ tb/sv/tb_vec3_arithmetic_unit_top.sv @@
// Self-checking testbench for the three-component fixed-point vector unit.
module tb_vec3_arithmetic_unit_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [71:0] wide_t;

	typedef struct {
		logic [3:0]      cmd;
		v3au_pkg::fx_t   a [3];
		v3au_pkg::fx_t   b [3];
		v3au_pkg::fx_t   f;
		int              gap;
		bit              drain;
	} op_t;

	typedef struct {
		v3au_pkg::fx_t r [3];
		v3au_pkg::fx_t s;
		logic zero;
		logic sat;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, zero_length, saturated;
	v3au_pkg::fx_t r_x, r_y, r_z, r_scalar;
	op_t cur;

	op_t  pending_ops [$];
	res_t expected_res [$];
	int errors = 0;
	int checked = 0;
	int wait_cnt = 0;
	int cmd_hits [16];
	bit stim_done = 1'b0;

	vec3_arithmetic_unit_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cur.cmd), .a_x(cur.a[0]), .a_y(cur.a[1]), .a_z(cur.a[2]),
		.b_x(cur.b[0]), .b_y(cur.b[1]), .b_z(cur.b[2]), .factor(cur.f),
		.done(done), .r_x(r_x), .r_y(r_y), .r_z(r_z), .r_scalar(r_scalar),
		.zero_length(zero_length), .saturated(saturated)
	);

	always #5 clk = ~clk;

	function automatic v3au_pkg::fx_t clamp32(wide_t v, ref logic sat);
		if (v > 72'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -72'sd2147483648) begin
			sat = 1'b1;
			return 32'sh80000000;
		end
		return v3au_pkg::fx_t'(v);
	endfunction

	function automatic wide_t fx_round(wide_t v);
		return (v + 72'sd32768) >>> 16;
	endfunction

	function automatic wide_t sqrt_round(wide_t s);
		wide_t r, t;
		r = 0;
		for (int i = 33; i >= 0; i--) begin
			t = r | (72'sd1 <<< i);
			if (t * t <= s)
				r = t;
		end
		if (s - r * r > r)
			r = r + 1;
		return r;
	endfunction

	function automatic wide_t div_near(wide_t num, wide_t den);
		wide_t m;
		m = (num < 0) ? -num : num;
		m = (m + den / 2) / den;
		return (num < 0) ? -m : m;
	endfunction

	function automatic res_t vec_predict(op_t op);
		res_t e;
		wide_t a [3], b [3], f, rv [3], rs, ss, m;
		logic sat;
		for (int i = 0; i < 3; i++) begin
			a[i] = op.a[i];
			b[i] = op.b[i];
			rv[i] = 0;
		end
		f = op.f;
		rs = 0;
		sat = 1'b0;
		e.zero = 1'b0;
		ss = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
		case (op.cmd)
			v3au_pkg::CMD_ADD: for (int i = 0; i < 3; i++) rv[i] = a[i] + b[i];
			v3au_pkg::CMD_SUB: for (int i = 0; i < 3; i++) rv[i] = a[i] - b[i];
			v3au_pkg::CMD_CROSS: begin
				rv[0] = fx_round(a[1] * b[2] - a[2] * b[1]);
				rv[1] = fx_round(a[2] * b[0] - a[0] * b[2]);
				rv[2] = fx_round(a[0] * b[1] - a[1] * b[0]);
			end
			v3au_pkg::CMD_SCALE: for (int i = 0; i < 3; i++) rv[i] = fx_round(a[i] * f);
			v3au_pkg::CMD_DOT: rs = fx_round(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
			v3au_pkg::CMD_MAGSQ: rs = fx_round(ss);
			v3au_pkg::CMD_MAG: rs = sqrt_round(ss);
			v3au_pkg::CMD_NORM, v3au_pkg::CMD_SETMAG: begin
				e.zero = (ss == 0);
				m = (ss == 0) ? 72'sd65536 : sqrt_round(ss);
				for (int i = 0; i < 3; i++)
					rv[i] = div_near(a[i] *
						((op.cmd == v3au_pkg::CMD_NORM) ? 72'sd65536 : f), m);
			end
			default: ;
		endcase
		for (int i = 0; i < 3; i++) e.r[i] = clamp32(rv[i], sat);
		e.s = clamp32(rs, sat);
		e.sat = sat;
		return e;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("ERROR t=%0t beat %0d: %s got %h expected %h", $time, checked, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		bit launched;
		if (!arst_n) begin
			start <= 1'b0;
			wait_cnt <= 0;
		end else begin
			launched = start && !busy;
			if (launched) begin
				expected_res.push_back(vec_predict(cur));
				cmd_hits[cur.cmd]++;
			end
			if (start && !launched) begin
				start <= 1'b1;
			end else if (pending_ops.size() == 0) begin
				start <= 1'b0;
			end else if (wait_cnt < pending_ops[0].gap ||
					(pending_ops[0].drain && (launched || expected_res.size() != 0))) begin
				start <= 1'b0;
				wait_cnt <= wait_cnt + 1;
			end else begin
				cur <= pending_ops.pop_front();
				start <= 1'b1;
				wait_cnt <= 0;
			end
		end
	end

	always @(posedge clk) begin
		res_t e;
		if (arst_n && done) begin
			if (expected_res.size() == 0) begin
				report("result beat with nothing pending", {31'b0, done}, 32'd0);
			end else begin
				e = expected_res.pop_front();
				if (r_x !== e.r[0]) report("r_x", r_x, e.r[0]);
				if (r_y !== e.r[1]) report("r_y", r_y, e.r[1]);
				if (r_z !== e.r[2]) report("r_z", r_z, e.r[2]);
				if (r_scalar !== e.s) report("r_scalar", r_scalar, e.s);
				if (zero_length !== e.zero) report("zero_length", zero_length, e.zero);
				if (saturated !== e.sat) report("saturated", saturated, e.sat);
				checked++;
			end
		end
	end

	function automatic v3au_pkg::fx_t rand_fx();
		case ($urandom_range(0, 4))
			0: return v3au_pkg::fx_t'($urandom);
			1: return v3au_pkg::fx_t'($urandom_range(0, 32'h200000)) - 32'sh100000;
			2: return v3au_pkg::fx_t'($urandom_range(0, 32'h2000000)) - 32'sh1000000;
			3: case ($urandom_range(0, 4))
				0: return 32'sh7fffffff;
				1: return 32'sh80000000;
				2: return 32'sh00010000;
				3: return -32'sh1;
				default: return 32'sh0;
			endcase
			default: return v3au_pkg::fx_t'($urandom);
		endcase
	endfunction

	task automatic add_op(logic [3:0] c, v3au_pkg::fx_t ax, v3au_pkg::fx_t ay,
			v3au_pkg::fx_t az, v3au_pkg::fx_t bx, v3au_pkg::fx_t by, v3au_pkg::fx_t bz,
			v3au_pkg::fx_t f, int gap, bit drain);
		op_t op;
		op.cmd = c;
		op.a[0] = ax; op.a[1] = ay; op.a[2] = az;
		op.b[0] = bx; op.b[1] = by; op.b[2] = bz;
		op.f = f;
		op.gap = gap;
		op.drain = drain;
		pending_ops.push_back(op);
	endtask

	initial begin
		v3au_pkg::fx_t mx, mn, one;
		int gap, sel;
		logic [3:0] c;
		v3au_pkg::fx_t v [7];
		mx = 32'sh7fffffff;
		mn = 32'sh80000000;
		one = 32'sh00010000;
		add_op(v3au_pkg::CMD_ADD, mx, mn, one, mx, mn, -one, 0, 0, 0);
		add_op(v3au_pkg::CMD_SUB, mx, mn, 0, mn, mx, one, 0, 0, 0);
		add_op(v3au_pkg::CMD_CROSS, one, 2 * one, 3 * one, 4 * one, 5 * one, 6 * one, 0, 0, 0);
		add_op(v3au_pkg::CMD_CROSS, mx, mn, mx, mn, mx, mn, 0, 0, 0);
		add_op(v3au_pkg::CMD_SCALE, one, -one, mx, 0, 0, 0, mn, 0, 0);
		add_op(v3au_pkg::CMD_SCALE, 3, -3, 32'sh8000, 0, 0, 0, 32'sh8000, 0, 0);
		add_op(v3au_pkg::CMD_DOT, mn, mn, mn, mn, mn, mn, 0, 0, 0);
		add_op(v3au_pkg::CMD_DOT, one, one, one, -one, 2 * one, 0, 0, 0, 0);
		add_op(v3au_pkg::CMD_MAGSQ, mn, mx, mn, 0, 0, 0, 0, 0, 0);
		add_op(v3au_pkg::CMD_MAGSQ, 3 * one, 4 * one, 0, 0, 0, 0, 0, 0, 0);
		add_op(v3au_pkg::CMD_MAG, mn, mn, mn, 0, 0, 0, 0, 0, 0);
		add_op(v3au_pkg::CMD_MAG, 3 * one, 4 * one, 12 * one, 0, 0, 0, 0, 0, 0);
		add_op(v3au_pkg::CMD_NORM, 0, 0, 0, mx, mx, mx, mx, 0, 0);
		add_op(v3au_pkg::CMD_NORM, 3 * one, -4 * one, 0, 0, 0, 0, 0, 0, 0);
		add_op(v3au_pkg::CMD_NORM, mn, 1, 0, 0, 0, 0, 0, 0, 0);
		add_op(v3au_pkg::CMD_SETMAG, 0, 0, 0, 0, 0, 0, 5 * one, 0, 0);
		add_op(v3au_pkg::CMD_SETMAG, 1, 0, 0, 0, 0, 0, mx, 0, 0);
		add_op(v3au_pkg::CMD_SETMAG, 3 * one, 4 * one, 0, 0, 0, 0, mn, 0, 0);
		add_op(4'd9, mx, mx, mx, mx, mx, mx, mx, 0, 0);
		add_op(4'd15, mn, mn, mn, mn, mn, mn, mn, 0, 1);
		for (int n = 0; n < 800; n++) begin
			if (n < 250) gap = 0;
			else if (n < 500) gap = ($urandom_range(0, 99) < 51) ? $urandom_range(1, 3) : 0;
			else if (n < 650) gap = ($urandom_range(0, 99) < 9) ? 1 : 0;
			else gap = ($urandom_range(0, 99) < 30) ? $urandom_range(1, 80) : 0;
			sel = $urandom_range(0, 19);
			c = (sel == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
			for (int i = 0; i < 7; i++) v[i] = rand_fx();
			if ((c == v3au_pkg::CMD_NORM || c == v3au_pkg::CMD_SETMAG) &&
					$urandom_range(0, 9) == 0) begin
				v[0] = 0; v[1] = 0; v[2] = 0;
			end
			add_op(c, v[0], v[1], v[2], v[3], v[4], v[5], v[6], gap, n == 400);
		end
		stim_done = 1'b1;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done);
		@(posedge clk);
		while (pending_ops.size() != 0 || start || expected_res.size() != 0)
			@(posedge clk);
		repeat (v3au_pkg::SQ_LAT + v3au_pkg::DIV_LAT + 10) @(posedge clk);
		$display("Checked %0d result beats over all nine commands plus unknown codes;", checked);
		$display("add %0d cross %0d norm %0d setmag %0d, zero vectors, extremes, random gaps.",
			cmd_hits[v3au_pkg::CMD_ADD], cmd_hits[v3au_pkg::CMD_CROSS],
			cmd_hits[v3au_pkg::CMD_NORM], cmd_hits[v3au_pkg::CMD_SETMAG]);
		if (errors == 0 && expected_res.size() == 0) begin
			$display("vec3_arithmetic_unit_top: match");
		end else begin
			$display("vec3_arithmetic_unit_top: mismatch");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("vec3_arithmetic_unit_top: mismatch");
		$finish;
	end
endmodule
